[design/rsc_pkg.sv]
// Shared types and constants of the RGB 3x3 sharpen filter.
`timescale 1ns / 1ps

package rsc_pkg;

    localparam int PIX_CH_W = 8;
    localparam int PIX_W    = 3 * PIX_CH_W;

    // Configuration port
    localparam int COLS_CFG_W = 11;
    localparam int ROWS_CFG_W = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS = 1'b1;

    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 11'd1024;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 13'd4096;

    // Smallest frame edge that still has an interior pixel
    localparam int MIN_SIZE = 3;

    // Result coordinates
    localparam int OUT_ROW_W = 12;
    localparam int OUT_COL_W = 10;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_ROW_W - OUT_COL_W - PIX_W;

    typedef struct packed {
        logic [PIX_CH_W-1:0] red;
        logic [PIX_CH_W-1:0] green;
        logic [PIX_CH_W-1:0] blue;
    } pix_t;

    typedef struct packed {
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 last;
    } pos_t;

endpackage

[design/rsc_kernel.sv]
// Sharpen kernel arithmetic: weighted sum stage, divide by nine and saturate stage.
`timescale 1ns / 1ps

module rsc_kernel
    import rsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   win_valid,
    output logic                   win_ready,
    input  pos_t                   win_pos,
    input  pix_t [8:0]             window,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int SUM_W  = 12;
    localparam int DIFF_W = 13;
    localparam int PROD_W = 25;
    // floor(x / 9) == (x * 7282) >> 16 for 0 <= x < 4096
    localparam logic [PROD_W-1:0] DIV9_RECIP = 25'd7282;
    localparam int DIV9_SHIFT = 16;
    localparam int QUOT_W = PROD_W - DIV9_SHIFT;

    logic                                dif_valid_reg;
    pos_t                                dif_pos_reg;
    logic signed [2:0][DIFF_W-1:0]       dif_val_reg;
    logic signed [2:0][DIFF_W-1:0]       dif_val_next;

    logic                                out_valid_reg;
    pos_t                                out_pos_reg;
    logic [PIX_W-1:0]                    out_pix_reg;
    logic [PIX_W-1:0]                    out_pix_next;

    logic out_free;
    logic dif_free;

    assign out_free  = !out_valid_reg || m_tready;
    assign dif_free  = !dif_valid_reg || out_free;
    assign win_ready = dif_free;

    // 10 * centre - neighbours == 11 * centre - sum of all nine
    always_comb
    begin
        logic [SUM_W-1:0] sum;
        logic [SUM_W-1:0] c11;
        logic [PIX_W-1:0] w;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum = '0;
            for (int k = 0; k < 9; k++)
            begin
                w   = window[k];
                sum = sum + SUM_W'(w[ch*PIX_CH_W +: PIX_CH_W]);
            end
            w   = window[4];
            c11 = SUM_W'(w[ch*PIX_CH_W +: PIX_CH_W]) * SUM_W'(11);
            dif_val_next[ch] = $signed({1'b0, c11}) - $signed({1'b0, sum});
        end
    end

    // Negative sums truncate toward zero and clip to zero; large ones clip to 255
    always_comb
    begin
        logic [PROD_W-1:0] prod;
        logic [QUOT_W-1:0] quot;
        for (int ch = 0; ch < 3; ch++)
        begin
            prod = PROD_W'(dif_val_reg[ch][DIFF_W-2:0]) * DIV9_RECIP;
            quot = prod[PROD_W-1:DIV9_SHIFT];
            if (dif_val_reg[ch][DIFF_W-1])
            begin
                out_pix_next[ch*PIX_CH_W +: PIX_CH_W] = '0;
            end
            else if (quot > QUOT_W'(255))
            begin
                out_pix_next[ch*PIX_CH_W +: PIX_CH_W] = '1;
            end
            else
            begin
                out_pix_next[ch*PIX_CH_W +: PIX_CH_W] = quot[PIX_CH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dif_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (dif_free)
            begin
                dif_valid_reg <= win_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= dif_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_valid && dif_free)
        begin
            dif_pos_reg <= win_pos;
            dif_val_reg <= dif_val_next;
        end
        if (dif_valid_reg && out_free)
        begin
            out_pos_reg <= dif_pos_reg;
            out_pix_reg <= out_pix_next;
        end
    end

    pix_t out_pix;
    assign out_pix  = pix_t'(out_pix_reg);
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_pos_reg.last;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_pix.blue, out_pix.green, out_pix.red,
                       out_pos_reg.col, out_pos_reg.row};

endmodule

[design/rgb_sharpen_conv3x3_unit.sv]
// Top level of the streaming RGB 3x3 sharpen filter with line store and window.
`timescale 1ns / 1ps
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata: red, green, blue; tuser: start of frame
//  m_*      out  m_tvalid/m_tready    tdata: row, col, red, green, blue; tlast: frame done
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index: register, cfg_data: value
//
//  One pixel per clock sustained while m_tready is high. After its pixel transfer a result
//  is registered by line store read, window update, weighted sum and divide in turn.
//  The single-port-per-side line store reads on transfer and writes back as the item
//  leaves the line store stage; a same-address read on the edge of a write is forwarded.
//  Reset clears counters, window and pipeline valids and loads 1024 x 4096; the line
//  store is not cleared, so no clearing pass is needed.
//  A stalled m_tready holds each full stage; bubbles in the pipe still take input.

module rgb_sharpen_conv3x3_unit
    import rsc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,    // [7:0] pix_red, [15:8] pix_green, [23:16] pix_blue
    input  logic                   s_tuser,    // [0] start_of_frame
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,    // [11:0] out_row, [21:12] out_col,
                                               // [29:22] out_red, [37:30] out_green,
                                               // [45:38] out_blue, [47:46] zero
    output logic                   m_tlast,    // frame_done
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Counter and compare widths follow the frame limits
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int CSW = (CW + 1 > COLS_CFG_W) ? CW + 1 : COLS_CFG_W;
    localparam int RSW = (RW + 1 > ROWS_CFG_W) ? RW + 1 : ROWS_CFG_W;
    localparam int CXW = (CW > OUT_COL_W) ? CW : OUT_COL_W;
    localparam int RXW = (RW > OUT_ROW_W) ? RW : OUT_ROW_W;

    // ------------------------------------------------------------------
    // Configuration registers, clamped where used
    // ------------------------------------------------------------------
    logic [COLS_CFG_W-1:0] cols_cfg_reg;
    logic [ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [CSW-1:0]        cols_raw;
    logic [RSW-1:0]        rows_raw;
    logic [CSW-1:0]        cols_eff;
    logic [RSW-1:0]        rows_eff;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= COLS_RESET;
            rows_cfg_reg <= ROWS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_IMAGE_COLS: cols_cfg_reg <= cfg_data[COLS_CFG_W-1:0];
                CFG_IMAGE_ROWS: rows_cfg_reg <= cfg_data[ROWS_CFG_W-1:0];
            endcase
        end
    end

    assign cols_raw = CSW'(cols_cfg_reg);
    assign rows_raw = RSW'(rows_cfg_reg);
    assign cols_eff = (cols_raw < CSW'(MIN_SIZE))  ? CSW'(MIN_SIZE)  :
                      (cols_raw > CSW'(MAX_WIDTH)) ? CSW'(MAX_WIDTH) : cols_raw;
    assign rows_eff = (rows_raw < RSW'(MIN_SIZE))   ? RSW'(MIN_SIZE)   :
                      (rows_raw > RSW'(MAX_HEIGHT)) ? RSW'(MAX_HEIGHT) : rows_raw;

    // ------------------------------------------------------------------
    // Transfer stage: position, line store read
    // ------------------------------------------------------------------
    logic          accept;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [CSW-1:0] c_x;
    logic [RSW-1:0] r_x;
    logic [CSW-1:0] col_step;
    logic [RSW-1:0] row_step;
    logic [CXW-1:0] col_m1;
    logic [RXW-1:0] row_m1;
    logic          cur_emit;
    pos_t          cur_pos;
    pix_t          pix_in;

    assign accept  = s_tvalid && s_tready;
    assign cur_col = s_tuser ? '0 : col_reg;
    assign cur_row = s_tuser ? '0 : row_reg;
    assign c_x     = CSW'(cur_col);
    assign r_x     = RSW'(cur_row);

    assign pix_in.red   = s_tdata[PIX_CH_W-1:0];
    assign pix_in.green = s_tdata[2*PIX_CH_W-1:PIX_CH_W];
    assign pix_in.blue  = s_tdata[3*PIX_CH_W-1:2*PIX_CH_W];

    // The window centred one row up and one column left is complete
    assign cur_emit = (r_x >= RSW'(2)) && (c_x >= CSW'(2)) &&
                      (r_x < rows_eff) && (c_x < cols_eff);

    assign col_m1       = CXW'(cur_col) - CXW'(1);
    assign row_m1       = RXW'(cur_row) - RXW'(1);
    assign cur_pos.row  = row_m1[OUT_ROW_W-1:0];
    assign cur_pos.col  = col_m1[OUT_COL_W-1:0];
    assign cur_pos.last = (r_x == rows_eff - RSW'(1)) && (c_x == cols_eff - CSW'(1));

    // Wrap at end of row and frame, also past a shrunk size
    always_comb
    begin
        col_step = c_x + CSW'(1);
        row_step = r_x + RSW'(1);
        if (col_step >= cols_eff)
        begin
            col_next = '0;
            row_next = (row_step >= rows_eff) ? '0 : row_step[RW-1:0];
        end
        else
        begin
            col_next = col_step[CW-1:0];
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store stage: read data arrives, write back shifted column
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    pix_t              s1_pix_reg;
    logic [CW-1:0]     s1_addr_reg;
    logic              s1_emit_reg;
    pos_t              s1_pos_reg;
    logic              s1_adv;

    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];   // {row before previous, previous row}
    logic [2*PIX_W-1:0] rd_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic               fwd_hit_reg;
    logic [2*PIX_W-1:0] above;
    logic [2*PIX_W-1:0] wr_data;
    pix_t               above1;
    pix_t               above2;

    logic              win_valid_reg;
    logic              win_ready;
    logic              win_free;
    pos_t              win_pos_reg;
    pix_t [8:0]        win_reg;
    pix_t [8:0]        win_next;

    assign win_free = !win_valid_reg || win_ready;
    assign s1_adv   = s1_valid_reg && win_free;
    assign s_tready = !s1_valid_reg || win_free;

    assign above   = fwd_hit_reg ? fwd_data_reg : rd_reg;
    assign above1  = pix_t'(above[PIX_W-1:0]);
    assign above2  = pix_t'(above[2*PIX_W-1:PIX_W]);
    assign wr_data = {above1, s1_pix_reg};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg <= line_mem[cur_col];
        end
        if (s1_adv)
        begin
            line_mem[s1_addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                // The write of the item ahead lands on the same edge as this read
                fwd_hit_reg  <= s1_valid_reg && (cur_col == s1_addr_reg);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= pix_in;
            s1_addr_reg  <= cur_col;
            s1_emit_reg  <= cur_emit;
            s1_pos_reg   <= cur_pos;
            fwd_data_reg <= wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Window stage: shift left, bring in the new column top row first
    // ------------------------------------------------------------------
    always_comb
    begin
        win_next = win_reg;
        for (int k = 0; k < 3; k++)
        begin
            win_next[3*k]     = win_reg[3*k + 1];
            win_next[3*k + 1] = win_reg[3*k + 2];
        end
        win_next[2] = above2;
        win_next[5] = above1;
        win_next[8] = s1_pix_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else if (s1_adv)
        begin
            win_valid_reg <= s1_emit_reg;
            win_reg       <= win_next;
        end
        else if (win_ready)
        begin
            win_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_pos_reg <= s1_pos_reg;
        end
    end

    // ------------------------------------------------------------------
    // Kernel arithmetic and output register
    // ------------------------------------------------------------------
    rsc_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .win_valid (win_valid_reg),
        .win_ready (win_ready),
        .win_pos   (win_pos_reg),
        .window    (win_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (CSW'(col_reg) < $past(cols_eff)))
        else $error("column counter left the row after a transfer");

    a_fwd_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_hit_reg |-> (s1_addr_reg == $past(s1_addr_reg)))
        else $error("forwarded line store data for a different column");

    a_win_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid_reg && !win_ready) |=> ($stable(win_reg) && $stable(win_pos_reg)))
        else $error("window changed while its result was stalled");

endmodule
